// ===== design/lvitc_pkg.sv =====
// Shared types and constants for the light vector inverse transform colour block.
// No dependencies; used by light_vector_inverse_transform_color.
package lvitc_pkg;

  localparam int ENTRY_W   = 16;  // matrix entries and light components
  localparam int CF_W      = 33;  // cofactor (difference of two 16x16 products)
  localparam int WW        = 50;  // determinant and transformed vector, signed
  localparam int MAG_W     = 49;  // magnitude of a transformed component
  localparam int TOP_W     = 6;   // bit index into a magnitude
  localparam int NORM_TOP  = 29;  // normalised magnitudes have their top bit here
  localparam int NORM_W    = 30;
  localparam int SQ_W      = 62;  // sum of three squares
  localparam int ROOT_W    = 31;
  localparam int ROOT_STEPS = 31; // one root bit per pipeline stage
  localparam int COL_W     = 8;
  localparam int NUM_COL   = 5;

  // Register map, by word index
  localparam logic [1:0] REG_LIGHT_X = 2'd0;
  localparam logic [1:0] REG_LIGHT_Y = 2'd1;
  localparam logic [1:0] REG_LIGHT_Z = 2'd2;

  localparam logic [ENTRY_W-1:0] LIGHT_X_RST = 16'd0;
  localparam logic [ENTRY_W-1:0] LIGHT_Y_RST = 16'd0;
  localparam logic [ENTRY_W-1:0] LIGHT_Z_RST = 16'd16384;

  // Colour outputs: front red, front green, front blue, back green, back blue.
  // Each takes one vector lane; flip marks colours built from the negated lane.
  localparam logic [1:0] COL_LANE [NUM_COL] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2};
  localparam logic       COL_FLIP [NUM_COL] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1};

  // Payload carried alongside the square root
  typedef struct packed {
    logic [2:0][NORM_W-1:0] nm;
    logic [2:0]             neg;
    logic                   degen;
  } root_side_t;

  function automatic logic signed [CF_W-1:0] mul_diff(
    input logic signed [ENTRY_W-1:0] p,
    input logic signed [ENTRY_W-1:0] q,
    input logic signed [ENTRY_W-1:0] r,
    input logic signed [ENTRY_W-1:0] s
  );
    logic signed [CF_W-1:0] x;
    logic signed [CF_W-1:0] y;
    begin
      x = CF_W'(p) * CF_W'(q);
      y = CF_W'(r) * CF_W'(s);
      return x - y;
    end
  endfunction

endpackage

// ===== design/light_vector_inverse_transform_color.sv =====
// Top level of the light vector inverse transform colour block: full pipeline.
// Depends on lvitc_pkg for widths, register map and colour lane table.
//
// Usage
//   Input channel: drive the nine Q1.14 entries of the matrix's upper-left 3x3
//   part on in_e_r*c* and pulse start; a transaction is taken at every clock
//   edge where start is high and busy is low. busy stays low, so one matrix
//   may enter in every cycle.
//   Result channel: out_valid marks one cycle in which the five biased
//   colours and the degenerate flag are valid; results leave in input order.
//   There is no back-pressure: the receiver takes each result in that cycle.
//   Pipeline from an accepted start to its out_valid: nine set-up stages
//   (capture, cofactors, products, sums, magnitudes, leading one,
//   normalisation, squares and sum of squares), 31 square-root stages, one
//   bit per stage, then one division set-up stage, FRAC_BITS + 1 quotient
//   stages and the colour stage. Throughput: one transaction per cycle.
//   Configuration: APB registers at byte address 0 (light_x), 4 (light_y)
//   and 8 (light_z), 16 bits each; write them only while no transaction is
//   in flight. pready is tied high.
//   Reset: rst_n low clears every valid bit and loads the light direction
//   (0, 0, 1.0); data in flight is dropped.
module light_vector_inverse_transform_color #(
  parameter int FRAC_BITS = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic signed [15:0] in_e_r0c0,
  input  logic signed [15:0] in_e_r0c1,
  input  logic signed [15:0] in_e_r0c2,
  input  logic signed [15:0] in_e_r1c0,
  input  logic signed [15:0] in_e_r1c1,
  input  logic signed [15:0] in_e_r1c2,
  input  logic signed [15:0] in_e_r2c0,
  input  logic signed [15:0] in_e_r2c1,
  input  logic signed [15:0] in_e_r2c2,
  output logic        out_valid,
  output logic [7:0]  out_front_red,
  output logic [7:0]  out_front_green,
  output logic [7:0]  out_front_blue,
  output logic [7:0]  out_back_green,
  output logic [7:0]  out_back_blue,
  output logic        out_degenerate,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int EW  = lvitc_pkg::ENTRY_W;
  localparam int NW  = lvitc_pkg::ROOT_W + FRAC_BITS;   // division remainder
  localparam int QW  = FRAC_BITS + 1;                   // quotient, capped at 1.0
  localparam int DS  = FRAC_BITS + 1;                   // quotient stages
  localparam int UW  = FRAC_BITS + 2;                   // biased component
  localparam int PW  = FRAC_BITS + 10;                  // biased component * 255
  localparam int LAT = FRAC_BITS + 43;
  localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [EW-1:0] light_r [3];
  logic          cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_r[0] <= lvitc_pkg::LIGHT_X_RST;
      light_r[1] <= lvitc_pkg::LIGHT_Y_RST;
      light_r[2] <= lvitc_pkg::LIGHT_Z_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        lvitc_pkg::REG_LIGHT_X: light_r[0] <= pwdata[EW-1:0];
        lvitc_pkg::REG_LIGHT_Y: light_r[1] <= pwdata[EW-1:0];
        lvitc_pkg::REG_LIGHT_Z: light_r[2] <= pwdata[EW-1:0];
        default: ;  // beyond the register map: drop the write
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      lvitc_pkg::REG_LIGHT_X: prdata = {16'd0, light_r[0]};
      lvitc_pkg::REG_LIGHT_Y: prdata = {16'd0, light_r[1]};
      lvitc_pkg::REG_LIGHT_Z: prdata = {16'd0, light_r[2]};
      default:                prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stage 1: capture the matrix
  // ---------------------------------------------------------------------------
  logic                 v1_r;
  logic signed [EW-1:0] a1_r [3][3];

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= start && !busy;
    a1_r[0][0] <= in_e_r0c0; a1_r[0][1] <= in_e_r0c1; a1_r[0][2] <= in_e_r0c2;
    a1_r[1][0] <= in_e_r1c0; a1_r[1][1] <= in_e_r1c1; a1_r[1][2] <= in_e_r1c2;
    a1_r[2][0] <= in_e_r2c0; a1_r[2][1] <= in_e_r2c1; a1_r[2][2] <= in_e_r2c2;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: cofactors, keep row 0 for the determinant
  // ---------------------------------------------------------------------------
  logic                                 v2_r;
  logic signed [lvitc_pkg::CF_W-1:0]    cf2_nxt [3][3];
  logic signed [lvitc_pkg::CF_W-1:0]    cf2_r   [3][3];
  logic signed [EW-1:0]                 a2_r    [3];

  always_comb begin
    cf2_nxt[0][0] =  lvitc_pkg::mul_diff(a1_r[1][1], a1_r[2][2], a1_r[1][2], a1_r[2][1]);
    cf2_nxt[0][1] = -lvitc_pkg::mul_diff(a1_r[1][0], a1_r[2][2], a1_r[1][2], a1_r[2][0]);
    cf2_nxt[0][2] =  lvitc_pkg::mul_diff(a1_r[1][0], a1_r[2][1], a1_r[1][1], a1_r[2][0]);
    cf2_nxt[1][0] = -lvitc_pkg::mul_diff(a1_r[0][1], a1_r[2][2], a1_r[0][2], a1_r[2][1]);
    cf2_nxt[1][1] =  lvitc_pkg::mul_diff(a1_r[0][0], a1_r[2][2], a1_r[0][2], a1_r[2][0]);
    cf2_nxt[1][2] = -lvitc_pkg::mul_diff(a1_r[0][0], a1_r[2][1], a1_r[0][1], a1_r[2][0]);
    cf2_nxt[2][0] =  lvitc_pkg::mul_diff(a1_r[0][1], a1_r[1][2], a1_r[0][2], a1_r[1][1]);
    cf2_nxt[2][1] = -lvitc_pkg::mul_diff(a1_r[0][0], a1_r[1][2], a1_r[0][2], a1_r[1][0]);
    cf2_nxt[2][2] =  lvitc_pkg::mul_diff(a1_r[0][0], a1_r[1][1], a1_r[0][1], a1_r[1][0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    cf2_r <= cf2_nxt;
    for (int j = 0; j < 3; j++) a2_r[j] <= a1_r[0][j];
  end

  // ---------------------------------------------------------------------------
  // Stage 3: determinant terms and cofactor * light products
  // ---------------------------------------------------------------------------
  logic                                 v3_r;
  logic signed [lvitc_pkg::WW-1:0]      dp3_r [3];
  logic signed [lvitc_pkg::WW-1:0]      wp3_r [3][3];

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
    for (int j = 0; j < 3; j++) begin
      dp3_r[j] <= lvitc_pkg::WW'(a2_r[j]) * lvitc_pkg::WW'(cf2_r[0][j]);
      for (int i = 0; i < 3; i++)
        wp3_r[i][j] <= lvitc_pkg::WW'(cf2_r[i][j]) * lvitc_pkg::WW'($signed(light_r[j]));
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: sums
  // ---------------------------------------------------------------------------
  logic                                 v4_r;
  logic signed [lvitc_pkg::WW-1:0]      det4_r;
  logic signed [lvitc_pkg::WW-1:0]      w4_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3_r;
    det4_r <= dp3_r[0] + dp3_r[1] + dp3_r[2];
    for (int i = 0; i < 3; i++) w4_r[i] <= wp3_r[i][0] + wp3_r[i][1] + wp3_r[i][2];
  end

  // ---------------------------------------------------------------------------
  // Stage 5: magnitudes, signs folded with the sign of the determinant
  // ---------------------------------------------------------------------------
  logic                                 v5_r;
  logic [lvitc_pkg::WW-1:0]             abs5_nxt [3];
  logic [2:0][lvitc_pkg::MAG_W-1:0]     mag5_r;
  logic [2:0]                           neg5_r;
  logic                                 deg5_r;

  always_comb begin
    for (int i = 0; i < 3; i++)
      abs5_nxt[i] = w4_r[i][lvitc_pkg::WW-1] ? lvitc_pkg::WW'(-w4_r[i])
                                             : lvitc_pkg::WW'(w4_r[i]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else        v5_r <= v4_r;
    for (int i = 0; i < 3; i++) begin
      mag5_r[i] <= abs5_nxt[i][lvitc_pkg::MAG_W-1:0];
      neg5_r[i] <= w4_r[i][lvitc_pkg::WW-1] ^ det4_r[lvitc_pkg::WW-1];
    end
    deg5_r <= (det4_r == '0) || ((w4_r[0] == '0) && (w4_r[1] == '0) && (w4_r[2] == '0));
  end

  // ---------------------------------------------------------------------------
  // Stage 6: position of the leading one over all three magnitudes
  // ---------------------------------------------------------------------------
  logic                                 v6_r;
  logic [lvitc_pkg::MAG_W-1:0]          mor6;
  logic [lvitc_pkg::TOP_W-1:0]          top6_nxt;
  logic [lvitc_pkg::TOP_W-1:0]          top6_r;
  logic [2:0][lvitc_pkg::MAG_W-1:0]     mag6_r;
  logic [2:0]                           neg6_r;
  logic                                 deg6_r;

  assign mor6 = mag5_r[0] | mag5_r[1] | mag5_r[2];

  always_comb begin
    top6_nxt = '0;
    for (int b = 0; b < lvitc_pkg::MAG_W; b++)
      if (mor6[b]) top6_nxt = lvitc_pkg::TOP_W'(b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else        v6_r <= v5_r;
    top6_r <= top6_nxt;
    mag6_r <= mag5_r;
    neg6_r <= neg5_r;
    deg6_r <= deg5_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 7: normalise so the largest magnitude has its top bit at NORM_TOP
  // ---------------------------------------------------------------------------
  localparam int XW = lvitc_pkg::MAG_W + lvitc_pkg::NORM_TOP;
  logic                                 v7_r;
  logic [XW-1:0]                        sh7_nxt [3];
  logic [2:0][lvitc_pkg::NORM_W-1:0]    nm7_r;
  logic [2:0]                           neg7_r;
  logic                                 deg7_r;

  always_comb begin
    for (int i = 0; i < 3; i++)
      sh7_nxt[i] = {mag6_r[i], {lvitc_pkg::NORM_TOP{1'b0}}} >> top6_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else        v7_r <= v6_r;
    for (int i = 0; i < 3; i++) nm7_r[i] <= sh7_nxt[i][lvitc_pkg::NORM_W-1:0];
    neg7_r <= neg6_r;
    deg7_r <= deg6_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 8: squares; stage 9: sum of squares
  // ---------------------------------------------------------------------------
  logic                                 v8_r;
  logic [lvitc_pkg::SQ_W-1:0]           sq8_r [3];
  lvitc_pkg::root_side_t                sd8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v8_r <= 1'b0;
    else        v8_r <= v7_r;
    for (int i = 0; i < 3; i++)
      sq8_r[i] <= lvitc_pkg::SQ_W'(nm7_r[i]) * lvitc_pkg::SQ_W'(nm7_r[i]);
    sd8_r.nm    <= nm7_r;
    sd8_r.neg   <= neg7_r;
    sd8_r.degen <= deg7_r;
  end

  // Square root pipeline: index 0 is stage 9, index k+1 holds step k
  logic                          rv_r   [lvitc_pkg::ROOT_STEPS+1];
  logic [lvitc_pkg::SQ_W-1:0]    rx_r   [lvitc_pkg::ROOT_STEPS+1];
  logic [lvitc_pkg::SQ_W-1:0]    rres_r [lvitc_pkg::ROOT_STEPS+1];
  lvitc_pkg::root_side_t         rsd_r  [lvitc_pkg::ROOT_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) rv_r[0] <= 1'b0;
    else        rv_r[0] <= v8_r;
    rx_r[0]   <= sq8_r[0] + sq8_r[1] + sq8_r[2];
    rres_r[0] <= '0;
    rsd_r[0]  <= sd8_r;
  end

  for (genvar k = 0; k < lvitc_pkg::ROOT_STEPS; k++) begin : g_root
    localparam logic [lvitc_pkg::SQ_W-1:0] BIT =
      lvitc_pkg::SQ_W'(1) << (2 * (lvitc_pkg::ROOT_STEPS - 1 - k));
    logic [lvitc_pkg::SQ_W-1:0] trial;
    logic [lvitc_pkg::SQ_W-1:0] x_nxt;
    logic [lvitc_pkg::SQ_W-1:0] res_nxt;

    always_comb begin
      trial = rres_r[k] + BIT;
      if (rx_r[k] >= trial) begin
        x_nxt   = rx_r[k] - trial;
        res_nxt = (rres_r[k] >> 1) + BIT;
      end else begin
        x_nxt   = rx_r[k];
        res_nxt = rres_r[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) rv_r[k+1] <= 1'b0;
      else        rv_r[k+1] <= rv_r[k];
      rx_r[k+1]   <= x_nxt;
      rres_r[k+1] <= res_nxt;
      rsd_r[k+1]  <= rsd_r[k];
    end
  end

  // ---------------------------------------------------------------------------
  // Division set-up: numerator (m << FRAC_BITS) + r/2 for each lane
  // ---------------------------------------------------------------------------
  logic [lvitc_pkg::ROOT_W-1:0] root;
  lvitc_pkg::root_side_t        rfin;

  assign root = rres_r[lvitc_pkg::ROOT_STEPS][lvitc_pkg::ROOT_W-1:0];
  assign rfin = rsd_r[lvitc_pkg::ROOT_STEPS];

  logic                          dv_r   [DS+1];
  logic [NW-1:0]                 drem_r [DS+1][3];
  logic [QW-1:0]                 dq_r   [DS+1][3];
  logic [lvitc_pkg::ROOT_W-1:0]  dr_r   [DS+1];
  logic [2:0]                    dneg_r [DS+1];
  logic                          ddeg_r [DS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r[0] <= 1'b0;
    else        dv_r[0] <= rv_r[lvitc_pkg::ROOT_STEPS];
    for (int i = 0; i < 3; i++) begin
      drem_r[0][i] <= (NW'(rfin.nm[i]) << FRAC_BITS) + NW'(root >> 1);
      dq_r[0][i]   <= '0;
    end
    dr_r[0]   <= root;
    dneg_r[0] <= rfin.neg;
    ddeg_r[0] <= rfin.degen;
  end

  // One quotient bit per stage, most significant first
  for (genvar j = 0; j < DS; j++) begin : g_div
    localparam int SH = FRAC_BITS - j;
    logic [NW-1:0] dsr;
    logic [NW-1:0] rem_nxt [3];
    logic [QW-1:0] q_nxt   [3];

    assign dsr = NW'(dr_r[j]) << SH;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        if (drem_r[j][i] >= dsr) begin
          rem_nxt[i] = drem_r[j][i] - dsr;
          q_nxt[i]   = dq_r[j][i] | (QW'(1) << SH);
        end else begin
          rem_nxt[i] = drem_r[j][i];
          q_nxt[i]   = dq_r[j][i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[j+1] <= 1'b0;
      else        dv_r[j+1] <= dv_r[j];
      drem_r[j+1] <= rem_nxt;
      dq_r[j+1]   <= q_nxt;
      dr_r[j+1]   <= dr_r[j];
      dneg_r[j+1] <= dneg_r[j];
      ddeg_r[j+1] <= ddeg_r[j];
    end
  end

  // ---------------------------------------------------------------------------
  // Colour stage: cap at 1.0, drop to zero when degenerate, bias and scale
  // ---------------------------------------------------------------------------
  logic [QW-1:0]             qc      [3];
  logic [UW-1:0]             u_nxt   [lvitc_pkg::NUM_COL];
  logic [PW-1:0]             p_nxt   [lvitc_pkg::NUM_COL];
  logic [lvitc_pkg::COL_W-1:0] col_nxt [lvitc_pkg::NUM_COL];
  logic [lvitc_pkg::COL_W-1:0] col_r   [lvitc_pkg::NUM_COL];
  logic                      ov_r;
  logic                      odeg_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (ddeg_r[DS])                                        qc[i] = '0;
      else if (dq_r[DS][i][FRAC_BITS] && (dq_r[DS][i] != ONE_Q)) qc[i] = ONE_Q;
      else                                                   qc[i] = dq_r[DS][i];
    end
    for (int c = 0; c < lvitc_pkg::NUM_COL; c++) begin
      if (dneg_r[DS][lvitc_pkg::COL_LANE[c]] ^ lvitc_pkg::COL_FLIP[c])
        u_nxt[c] = UW'(ONE_Q) - UW'(qc[lvitc_pkg::COL_LANE[c]]);
      else
        u_nxt[c] = UW'(ONE_Q) + UW'(qc[lvitc_pkg::COL_LANE[c]]);
      // u * 255 + 1.0, then drop FRAC_BITS + 1 bits
      p_nxt[c]   = (PW'(u_nxt[c]) << 8) - PW'(u_nxt[c]) + PW'(ONE_Q);
      col_nxt[c] = p_nxt[c][FRAC_BITS+8:FRAC_BITS+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else        ov_r <= dv_r[DS];
    col_r  <= col_nxt;
    odeg_r <= ddeg_r[DS];
  end

  assign out_valid       = ov_r;
  assign out_front_red   = col_r[0];
  assign out_front_green = col_r[1];
  assign out_front_blue  = col_r[2];
  assign out_back_green  = col_r[3];
  assign out_back_blue   = col_r[4];
  assign out_degenerate  = odeg_r;

`ifndef ASSERT_OFF
  // Every accepted transaction leaves the pipeline with an out_valid
  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted transaction did not produce a result");

  // No result appears without a matching accepted transaction
  a_latency_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without an accepted transaction");

  // A degenerate result sits at mid level on every colour
  a_degen_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |->
      (out_front_red == 8'd128 && out_front_green == 8'd128 &&
       out_front_blue == 8'd128 && out_back_green == 8'd128 &&
       out_back_blue == 8'd128))
    else $error("degenerate result not at mid level");

  // Front and back colours of one lane are complementary
  a_green_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((({1'b0, out_front_green} + {1'b0, out_back_green}) == 9'd255) ||
                   (({1'b0, out_front_green} + {1'b0, out_back_green}) == 9'd256)))
    else $error("front and back green not complementary");

  a_blue_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((({1'b0, out_front_blue} + {1'b0, out_back_blue}) == 9'd255) ||
                   (({1'b0, out_front_blue} + {1'b0, out_back_blue}) == 9'd256)))
    else $error("front and back blue not complementary");
`endif

endmodule
